>>> hw/rtl/ffha_pkg.sv
// Shared types and codes for the first-fit heap allocator.
package ffha_pkg;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NULL     = 2'd1;
	localparam logic [1:0] ST_NOMEM    = 2'd2;
	localparam logic [1:0] ST_BADPTR   = 2'd3;

	localparam int SIZE_W = 20;
	localparam int REQ_W  = 21;
	localparam int SPLIT_SLACK = 16;

	// Datapath commands issued by the controller
	typedef struct packed {
		logic clr_scan;   // restart scan index at zero
		logic inc_scan;   // advance scan index
		logic load_cur;   // read entry at scan index into current registers
		logic do_split;   // write chosen entry with rounded size, used
		logic mark_used;  // write chosen entry whole, used
		logic rd_up;      // read entry mv-1 into current registers
		logic wr_up;      // write current registers to entry mv, step mv down
		logic wr_ins;     // write new free entry at insert index
		logic free_cur;   // write chosen entry free, remember it
		logic rd_nxt;     // read entry after chosen
		logic rd_prv;     // read entry before chosen
		logic merge_next; // fold next into chosen
		logic merge_prev; // fold chosen into previous
		logic rd_dn;      // read entry mv+1 into current registers
		logic wr_dn;      // write current registers to entry mv, step mv up
		logic cnt_inc;
		logic cnt_dec;
		logic clr_tot;    // clear totals before recount
		logic acc_tot;    // accumulate scanned entry into totals
		logic latch_req;
	} ffha_cmd_t;

	// Datapath status back to the controller
	typedef struct packed {
		logic scan_end;   // scan index reached block count
		logic fit;        // scanned entry is free and large enough
		logic match;      // scanned entry is used and holds the offset
		logic can_split;
		logic next_free;  // entry after chosen exists and is free
		logic prev_free;  // entry before chosen exists and is free
		logic shift_done; // move index reached target
		logic req_zero;
		logic off_zero;
		logic func_rel;
	} ffha_sts_t;

endpackage

>>> hw/rtl/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator with coalescing.
// One request word is taken at a time. The block table has a single read
// port with registered data, so every entry visited is first read into
// registers and then used: an allocate walks the table until the first fit,
// then moves each later entry with one read and one write to open room on a
// split; a release walks likewise, reads both neighbors and moves entries
// down the same way once per merge. Every request that succeeds ends with a
// recount of the totals over all N entries, N being the block count (up to
// TABLE_ENTRIES); null and failed requests skip the recount. The result word
// is held in an output register until taken, and the next request is taken
// once it has left.
module first_fit_heap_allocator_core #(
	parameter int HEAP_BYTES    = 1048576,
	parameter int HEADER_BYTES  = 16,
	parameter int TABLE_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // func, request_size[20:0], block_offset[19:0], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // status, data_offset, used_bytes, free_bytes, zero pad
);
	import ffha_pkg::*;

	ffha_cmd_t cmd;
	ffha_sts_t sts;
	logic idle, done, in_fire;
	logic [1:0] status;
	logic [19:0] doff, ub, fb;
	logic [61:0] res_q;
	logic vld_q;

	assign s_tready = idle && !vld_q;
	assign in_fire = s_tvalid && s_tready;

	ffha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_busy(vld_q),
		.sts(sts), .cmd(cmd), .idle(idle), .done(done), .status(status)
	);

	ffha_dp #(
		.HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES),
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .func(s_tdata[0]),
		.request_size(s_tdata[21:1]), .block_offset(s_tdata[41:22]),
		.sts(sts), .data_offset(doff), .used_bytes(ub), .free_bytes(fb)
	);

	// Hold result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (done) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= {fb, ub, (status == ST_OK) ? doff : 20'd0, status};
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata = {2'b00, res_q};

endmodule

>>> hw/rtl/ffha_ctrl.sv
// Controller state machine of the first-fit heap allocator.
module ffha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               out_busy,
	input  ffha_pkg::ffha_sts_t sts,
	output ffha_pkg::ffha_cmd_t cmd,
	output logic               idle,
	output logic               done,
	output logic [1:0]         status
);
	import ffha_pkg::*;

	typedef enum logic [16:0] {
		S_IDLE  = 17'b00000000000000001,
		S_DEC   = 17'b00000000000000010,
		S_SRD   = 17'b00000000000000100,
		S_SCHK  = 17'b00000000000001000,
		S_URD   = 17'b00000000000010000,
		S_UWR   = 17'b00000000000100000,
		S_INS   = 17'b00000000001000000,
		S_NRD   = 17'b00000000010000000,
		S_PRD   = 17'b00000000100000000,
		S_FREE  = 17'b00000001000000000,
		S_DRD   = 17'b00000010000000000,
		S_DWR   = 17'b00000100000000000,
		S_MPRV  = 17'b00001000000000000,
		S_MNXT  = 17'b00010000000000000,
		S_CRD   = 17'b00100000000000000,
		S_CACC  = 17'b01000000000000000,
		S_DONE  = 17'b10000000000000000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] status_q, status_d;
	logic mprev_pend_q, mprev_pend_d;

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		status_d = status_q;
		mprev_pend_d = mprev_pend_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.latch_req = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.clr_scan = 1'b1;
				if (!sts.func_rel && sts.req_zero) begin
					status_d = ST_NULL;
					state_d = S_DONE;
				end else if (sts.func_rel && sts.off_zero) begin
					status_d = ST_NULL;
					state_d = S_DONE;
				end else begin
					state_d = S_SRD;
				end
			end
			S_SRD: begin
				if (sts.scan_end) begin
					status_d = sts.func_rel ? ST_BADPTR : ST_NOMEM;
					state_d = S_DONE;
				end else begin
					cmd.load_cur = 1'b1;
					state_d = S_SCHK;
				end
			end
			S_SCHK: begin
				status_d = ST_OK;
				if (!sts.func_rel && sts.fit) begin
					if (sts.can_split) begin
						cmd.do_split = 1'b1;
						state_d = S_URD;
					end else begin
						cmd.mark_used = 1'b1;
						cmd.clr_scan = 1'b1;
						cmd.clr_tot = 1'b1;
						state_d = S_CRD;
					end
				end else if (sts.func_rel && sts.match) begin
					cmd.free_cur = 1'b1;
					state_d = S_NRD;
				end else begin
					cmd.inc_scan = 1'b1;
					state_d = S_SRD;
				end
			end
			// Open a slot after the chosen entry, one read and one write per entry
			S_URD: begin
				if (sts.shift_done) begin
					state_d = S_INS;
				end else begin
					cmd.rd_up = 1'b1;
					state_d = S_UWR;
				end
			end
			S_UWR: begin
				cmd.wr_up = 1'b1;
				state_d = S_URD;
			end
			S_INS: begin
				cmd.wr_ins = 1'b1;
				cmd.cnt_inc = 1'b1;
				cmd.clr_scan = 1'b1;
				cmd.clr_tot = 1'b1;
				state_d = S_CRD;
			end
			// Fetch both neighbors of the freed entry
			S_NRD: begin
				cmd.rd_nxt = 1'b1;
				state_d = S_PRD;
			end
			S_PRD: begin
				cmd.rd_prv = 1'b1;
				state_d = S_FREE;
			end
			S_FREE: begin
				mprev_pend_d = sts.prev_free;
				if (sts.next_free) begin
					cmd.merge_next = 1'b1;
					state_d = S_DRD;
				end else if (sts.prev_free) begin
					cmd.merge_prev = 1'b1;
					mprev_pend_d = 1'b0;
					state_d = S_DRD;
				end else begin
					cmd.clr_scan = 1'b1;
					cmd.clr_tot = 1'b1;
					state_d = S_CRD;
				end
			end
			// Close the gap of a merged entry
			S_DRD: begin
				if (sts.shift_done) begin
					cmd.cnt_dec = 1'b1;
					state_d = mprev_pend_q ? S_MPRV : S_MNXT;
				end else begin
					cmd.rd_dn = 1'b1;
					state_d = S_DWR;
				end
			end
			S_DWR: begin
				cmd.wr_dn = 1'b1;
				state_d = S_DRD;
			end
			S_MPRV: begin
				cmd.merge_prev = 1'b1;
				mprev_pend_d = 1'b0;
				state_d = S_DRD;
			end
			S_MNXT: begin
				cmd.clr_scan = 1'b1;
				cmd.clr_tot = 1'b1;
				state_d = S_CRD;
			end
			S_CRD: begin
				if (sts.scan_end) begin
					state_d = S_DONE;
				end else begin
					cmd.load_cur = 1'b1;
					state_d = S_CACC;
				end
			end
			S_CACC: begin
				cmd.acc_tot = 1'b1;
				cmd.inc_scan = 1'b1;
				state_d = S_CRD;
			end
			S_DONE: begin
				if (!out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= ST_OK;
			mprev_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			status_q <= status_d;
			mprev_pend_q <= mprev_pend_d;
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE) && !out_busy;
	assign status = status_q;

endmodule

>>> hw/rtl/ffha_dp.sv
// Datapath of the first-fit heap allocator: block table, scan and totals.
module ffha_dp #(
	parameter int HEAP_BYTES    = 1048576,
	parameter int HEADER_BYTES  = 16,
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffha_pkg::ffha_cmd_t  cmd,
	input  logic                func,
	input  logic [20:0]         request_size,
	input  logic [19:0]         block_offset,
	output ffha_pkg::ffha_sts_t  sts,
	output logic [19:0]         data_offset,
	output logic [19:0]         used_bytes,
	output logic [19:0]         free_bytes
);
	import ffha_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int NW = REQ_W + 1;
	localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
	localparam logic [SIZE_W-1:0] INIT_SZ = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
	localparam logic [NW:0] SPLIT_MIN = (NW+1)'(HEADER_BYTES + SPLIT_SLACK);

	// Block table: one read port with registered data, one write port
	logic [SIZE_W-1:0] start_q [TABLE_ENTRIES];
	logic [SIZE_W-1:0] size_q  [TABLE_ENTRIES];
	logic              used_q  [TABLE_ENTRIES];

	logic [CW-1:0] count_q, scan_q, mv_q;
	logic [IW-1:0] sel_q;
	logic          func_q;
	logic [NW-1:0] need_q;
	logic [SIZE_W-1:0] off_q;
	logic [SIZE_W-1:0] cur_start_q, cur_size_q;
	logic          cur_used_q;
	logic [SIZE_W-1:0] nxt_size_q, prv_start_q, prv_size_q;
	logic          nxt_used_q, prv_used_q;
	logic [SIZE_W-1:0] sel_start_q, sel_size_q;
	logic [SIZE_W-1:0] used_tot_q, free_tot_q, doff_q;
	logic [SIZE_W-1:0] ins_start_q, ins_size_q;
	logic          zero_req_q;

	logic [IW-1:0] scan_ix, mv_ix, sel_nx, sel_pv, mv_pv, mv_nx;
	logic [NW:0]   size_ext, need_ext;
	logic [IW-1:0] rd_ix, wr_ix;
	logic [SIZE_W-1:0] rd_start, rd_size, wr_start, wr_size;
	logic [SIZE_W-1:0] merged_nx, merged_pv;
	logic          rd_used, wr_used, wr_en;

	assign scan_ix = scan_q[IW-1:0];
	assign mv_ix   = mv_q[IW-1:0];
	assign sel_nx  = sel_q + IW'(1);
	assign sel_pv  = sel_q - IW'(1);
	assign mv_pv   = mv_ix - IW'(1);
	assign mv_nx   = mv_ix + IW'(1);
	assign size_ext = (NW+1)'(cur_size_q);
	assign need_ext = (NW+1)'(need_q);
	assign merged_nx = sel_size_q + HDR + nxt_size_q;
	assign merged_pv = prv_size_q + HDR + sel_size_q;

	// Status toward the controller
	always_comb begin
		sts = '0;
		sts.scan_end = (scan_q >= count_q);
		sts.fit = !cur_used_q && (size_ext >= need_ext);
		sts.match = cur_used_q && ((cur_start_q + HDR) == off_q);
		sts.can_split = (count_q < CW'(TABLE_ENTRIES)) &&
			(size_ext >= need_ext + SPLIT_MIN);
		sts.next_free = ((CW'(sel_q) + CW'(1)) < count_q) && !nxt_used_q;
		sts.prev_free = (sel_q != '0) && !prv_used_q;
		sts.shift_done = func_q ? (mv_q + CW'(1) >= count_q) :
			(mv_q <= CW'(sel_q) + CW'(1));
		sts.req_zero = zero_req_q;
		sts.off_zero = (off_q == '0);
		sts.func_rel = func_q;
	end

	// Select the one table address read this cycle
	always_comb begin
		rd_ix = scan_ix;
		if (cmd.rd_up) rd_ix = mv_pv;
		else if (cmd.rd_dn) rd_ix = mv_nx;
		else if (cmd.rd_nxt) rd_ix = sel_nx;
		else if (cmd.rd_prv) rd_ix = sel_pv;
	end

	assign rd_start = start_q[rd_ix];
	assign rd_size  = size_q[rd_ix];
	assign rd_used  = used_q[rd_ix];

	// Select the one table entry written this cycle
	always_comb begin
		wr_en = 1'b1;
		wr_ix = scan_ix;
		wr_start = cur_start_q;
		wr_size = cur_size_q;
		wr_used = 1'b0;
		if (cmd.do_split) begin
			wr_size = need_q[SIZE_W-1:0];
			wr_used = 1'b1;
		end else if (cmd.mark_used) begin
			wr_used = 1'b1;
		end else if (cmd.free_cur) begin
			wr_used = 1'b0;
		end else if (cmd.wr_up || cmd.wr_dn) begin
			wr_ix = mv_ix;
			wr_used = cur_used_q;
		end else if (cmd.wr_ins) begin
			wr_ix = sel_nx;
			wr_start = ins_start_q;
			wr_size = ins_size_q;
		end else if (cmd.merge_next) begin
			wr_ix = sel_q;
			wr_start = sel_start_q;
			wr_size = merged_nx;
		end else if (cmd.merge_prev) begin
			wr_ix = sel_pv;
			wr_start = prv_start_q;
			wr_size = merged_pv;
		end else begin
			wr_en = 1'b0;
		end
	end

	// Table storage; entry 0 starts as one free block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q[0] <= '0;
			size_q[0] <= INIT_SZ;
			used_q[0] <= 1'b0;
		end else if (wr_en) begin
			start_q[wr_ix] <= wr_start;
			size_q[wr_ix] <= wr_size;
			used_q[wr_ix] <= wr_used;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(1);
			scan_q <= '0;
			mv_q <= '0;
			sel_q <= '0;
			used_tot_q <= '0;
			free_tot_q <= INIT_SZ;
		end else begin
			if (cmd.clr_scan) scan_q <= '0;
			else if (cmd.inc_scan) scan_q <= scan_q + CW'(1);
			if (cmd.cnt_inc) count_q <= count_q + CW'(1);
			else if (cmd.cnt_dec) count_q <= count_q - CW'(1);
			if (cmd.do_split) begin
				sel_q <= scan_ix;
				mv_q <= count_q;
			end
			if (cmd.free_cur) sel_q <= scan_ix;
			if (cmd.wr_up) mv_q <= mv_q - CW'(1);
			if (cmd.wr_dn) mv_q <= mv_q + CW'(1);
			// Merge removes entry sel+1 (next) or sel (into prev)
			if (cmd.merge_next) mv_q <= CW'(sel_nx);
			if (cmd.merge_prev) begin
				mv_q <= CW'(sel_q);
				sel_q <= sel_pv;
			end
			if (cmd.clr_tot) begin
				used_tot_q <= '0;
				free_tot_q <= '0;
			end else if (cmd.acc_tot) begin
				if (cur_used_q) used_tot_q <= used_tot_q + cur_size_q;
				else free_tot_q <= free_tot_q + cur_size_q;
			end
		end
	end

	// Request capture, registered read data and split values
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			func_q <= func;
			need_q <= (NW'(request_size) + NW'(3)) & ~NW'(3);
			zero_req_q <= (request_size == '0);
			off_q <= block_offset;
			doff_q <= '0;
		end
		if (cmd.load_cur || cmd.rd_up || cmd.rd_dn) begin
			cur_start_q <= rd_start;
			cur_size_q <= rd_size;
			cur_used_q <= rd_used;
		end
		if (cmd.rd_nxt) begin
			nxt_size_q <= rd_size;
			nxt_used_q <= rd_used;
		end
		if (cmd.rd_prv) begin
			prv_start_q <= rd_start;
			prv_size_q <= rd_size;
			prv_used_q <= rd_used;
		end
		if (cmd.do_split) begin
			ins_start_q <= cur_start_q + HDR + need_q[SIZE_W-1:0];
			ins_size_q <= cur_size_q - need_q[SIZE_W-1:0] - HDR;
		end
		if (cmd.do_split || cmd.mark_used) doff_q <= cur_start_q + HDR;
		if (cmd.free_cur) begin
			sel_start_q <= cur_start_q;
			sel_size_q <= cur_size_q;
		end
		if (cmd.merge_next) sel_size_q <= merged_nx;
	end

	assign data_offset = doff_q;
	assign used_bytes = used_tot_q;
	assign free_bytes = free_tot_q;

endmodule

>>> hw/rtl/ffha_checker.sv
// Port checker for the first-fit heap allocator, bound to the top level.
module ffha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);
	// Result word holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// No request taken while a result waits
	a_noin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("request taken while result pending");

	// Data offset zero unless status ok
	a_doff: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tdata[21:2] == 20'd0)
		else $error("data offset set on failed request");

	// Accepted request gives no result next cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid)
		else $error("result too early");
endmodule

bind first_fit_heap_allocator_core ffha_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
